// File: rtl/pfd_pkg.sv
// ----------------------------------------------------------------------------
// pfd_pkg
// Shared types and constants of the frame deframer with CRC-32 check.
// ----------------------------------------------------------------------------
`default_nettype none

package pfd_pkg;

	// Frame geometry
	localparam int unsigned IDX_W       = 10;
	localparam logic [IDX_W-1:0] IDX_MAX = '1;
	localparam int unsigned FRAME_LIMIT = 520;
	localparam int unsigned HDR_BYTES   = 4;
	localparam int unsigned PRE_BYTES   = 8;
	localparam int unsigned OVERHEAD    = 12;
	localparam int unsigned TAIL_BYTES  = 4;

	// Queue between the front and the back
	localparam int unsigned Q_DEPTH = 2;

	// CRC-32 (reflected, zlib)
	localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;
	localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;

	// Configuration register indexes
	localparam int unsigned CFG_IDX_W = 2;
	localparam int unsigned CFG_DATA_W = 10;
	localparam logic [CFG_IDX_W-1:0] CFG_DATA_TYPE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_ACK_TYPE  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_WIN   = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_PAY   = 2'd3;

	// Status codes
	localparam logic [2:0] ST_OK     = 3'd0;
	localparam logic [2:0] ST_TYPE   = 3'd1;
	localparam logic [2:0] ST_WINDOW = 3'd2;
	localparam logic [2:0] ST_LENGTH = 3'd3;
	localparam logic [2:0] ST_INCONS = 3'd4;
	localparam logic [2:0] ST_CRC    = 3'd5;

	// Result kinds
	localparam logic KIND_PAYLOAD = 1'b0;
	localparam logic KIND_STATUS  = 1'b1;

	typedef struct packed {
		logic [7:0] frame_byte;
		logic       frame_end;
	} in_t;

	typedef struct packed {
		logic        result_kind;
		logic [7:0]  payload_byte;
		logic [2:0]  packet_type;
		logic [4:0]  window_size;
		logic [7:0]  sequence_number;
		logic [15:0] payload_length;
		logic [31:0] time_stamp;
		logic [31:0] received_crc;
		logic [2:0]  status;
	} out_t;

	typedef struct packed {
		logic [2:0] data_type_code;
		logic [2:0] ack_type_code;
		logic [4:0] max_window;
		logic [9:0] max_payload;
	} cfg_t;

	// One classified word passed from the front to the back
	typedef struct packed {
		logic [7:0]       frame_byte;
		logic             last;
		logic [IDX_W-1:0] idx;
		logic             in_hdr;
		logic             in_stamp;
		logic             in_body;
	} q_entry_t;

	// Bytewise update of the reflected CRC-32
	function automatic logic [31:0] crc32_byte(input logic [31:0] c_in, input logic [7:0] b);
		logic [31:0] c;
		c = c_in ^ {24'h0, b};
		for (int k = 0; k < 8; k++) begin
			c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
		end
		return c;
	endfunction

endpackage

`default_nettype wire

// File: rtl/packet_frame_decoder_crc32.sv
// ----------------------------------------------------------------------------
// packet_frame_decoder_crc32
// Frame deframer: header and timestamp decode, payload pass-through and a
// CRC-32 check against the big-endian trailer of each frame.
//
//   channel  | signals                          | word
//   ---------+----------------------------------+------------------------------
//   frame    | frame_valid, frame_ready, frame  | one frame byte + end marker
//   result   | result_valid, result_ready,      | payload byte or end-of-frame
//            | result                           | status
//   config   | cfg_en, cfg_index, cfg_data      | register write, no handshake
//
// One byte per cycle sustained while the result is taken; each accepted byte
// waits in the queue, then the bytewise CRC update and the frame checks run in
// the same cycle as its pop, into the result register for payload and status.
// Reset clears the position counter, queue and frame state; registers return
// to their reset values. No clearing pass.
// A stalled result stops the back only; the front keeps taking bytes until
// the queue fills.
// ----------------------------------------------------------------------------
`default_nettype none

module packet_frame_decoder_crc32 #(
	parameter int unsigned MAX_PAYLOAD = 512
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              frame_valid,
	output logic                                   frame_ready,
	input  wire pfd_pkg::in_t                      frame,
	output logic                                   result_valid,
	input  wire logic                              result_ready,
	output pfd_pkg::out_t                          result,
	input  wire logic                              cfg_en,
	input  wire logic [pfd_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  wire logic [pfd_pkg::CFG_DATA_W-1:0]    cfg_data
);
	import pfd_pkg::*;

	cfg_t     cfg_q;
	logic     push;
	q_entry_t push_entry;
	logic     q_full;
	logic     pop;
	logic     q_not_empty;
	q_entry_t head;

	// Write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.data_type_code <= 3'd1;
			cfg_q.ack_type_code  <= 3'd2;
			cfg_q.max_window     <= 5'd31;
			cfg_q.max_payload    <= 10'(MAX_PAYLOAD);
		end else if (cfg_en) begin
			unique case (cfg_index)
				CFG_DATA_TYPE: cfg_q.data_type_code <= cfg_data[2:0];
				CFG_ACK_TYPE:  cfg_q.ack_type_code  <= cfg_data[2:0];
				CFG_MAX_WIN:   cfg_q.max_window     <= cfg_data[4:0];
				CFG_MAX_PAY:   cfg_q.max_payload    <= cfg_data[9:0];
			endcase
		end
	end

	pfd_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.frame_valid (frame_valid),
		.frame_ready (frame_ready),
		.frame       (frame),
		.push        (push),
		.push_entry  (push_entry),
		.q_full      (q_full)
	);

	pfd_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.full       (q_full),
		.pop        (pop),
		.not_empty  (q_not_empty),
		.head       (head)
	);

	pfd_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg_q),
		.q_not_empty  (q_not_empty),
		.head         (head),
		.pop          (pop),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

endmodule

`default_nettype wire

// File: rtl/pfd_front.sv
// ----------------------------------------------------------------------------
// pfd_front
// Accepts frame words, tracks the byte position and classifies each word.
// ----------------------------------------------------------------------------
`default_nettype none

module pfd_front (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            frame_valid,
	output logic                 frame_ready,
	input  wire pfd_pkg::in_t    frame,
	output logic                 push,
	output pfd_pkg::q_entry_t    push_entry,
	input  wire logic            q_full
);
	import pfd_pkg::*;

	logic [IDX_W-1:0] idx_q;

	assign frame_ready = !q_full;
	assign push        = frame_valid && frame_ready;

	// Classify the word by its position in the frame
	always_comb begin
		push_entry.frame_byte = frame.frame_byte;
		push_entry.last       = frame.frame_end;
		push_entry.idx        = idx_q;
		push_entry.in_hdr     = idx_q < IDX_W'(HDR_BYTES);
		push_entry.in_stamp   = idx_q >= IDX_W'(HDR_BYTES) && idx_q < IDX_W'(PRE_BYTES);
		push_entry.in_body    = idx_q >= IDX_W'(PRE_BYTES);
	end

	// Advance the saturating position, restart after the last word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
		end else if (push) begin
			if (frame.frame_end) begin
				idx_q <= '0;
			end else if (idx_q != IDX_MAX) begin
				idx_q <= idx_q + 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

// File: rtl/pfd_queue.sv
// ----------------------------------------------------------------------------
// pfd_queue
// Short queue of classified words between the front and the back.
// ----------------------------------------------------------------------------
`default_nettype none

module pfd_queue (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              push,
	input  wire pfd_pkg::q_entry_t push_entry,
	output logic                   full,
	input  wire logic              pop,
	output logic                   not_empty,
	output pfd_pkg::q_entry_t      head
);
	import pfd_pkg::*;

	localparam int unsigned PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(Q_DEPTH + 1);

	q_entry_t         slot_q [Q_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full      = count_q == CNT_W'(Q_DEPTH);
	assign not_empty = count_q != '0;
	assign head      = slot_q[rd_ptr_q];

	// Store pushed words
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_entry;
		end
	end

	// Advance pointers and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

// File: rtl/pfd_back.sv
// ----------------------------------------------------------------------------
// pfd_back
// Captures header and timestamp, runs the CRC through a four-byte delay,
// emits payload words and the end-of-frame status.
// ----------------------------------------------------------------------------
`default_nettype none

module pfd_back (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire pfd_pkg::cfg_t     cfg,
	input  wire logic              q_not_empty,
	input  wire pfd_pkg::q_entry_t head,
	output logic                   pop,
	output logic                   result_valid,
	input  wire logic              result_ready,
	output pfd_pkg::out_t          result
);
	import pfd_pkg::*;

	logic [31:0] header_q;
	logic [31:0] stamp_q;
	logic [31:0] crc_q;
	logic [31:0] tail_q;
	logic [2:0]  fill_q;
	logic        out_valid_q;
	out_t        out_q;

	logic [31:0] header_nx;
	logic [31:0] stamp_nx;
	logic [31:0] crc_nx;
	logic [31:0] tail_nx;
	logic [2:0]  fill_nx;
	logic [15:0] len;
	logic [2:0]  ptype;
	logic [4:0]  win;
	logic [10:0] n;
	logic [16:0] body_end;
	logic        emit_pay;
	logic [2:0]  status;
	logic [1:0]  hdr_lane;
	out_t        res;

	assign pop          = q_not_empty && (!out_valid_q || result_ready);
	assign result_valid = out_valid_q;
	assign result       = out_q;

	// Next frame state for the word at the head of the queue
	always_comb begin
		header_nx = header_q;
		stamp_nx  = stamp_q;
		hdr_lane  = 2'd3 - head.idx[1:0];
		if (head.in_hdr) begin
			header_nx[{hdr_lane, 3'b000} +: 8] = head.frame_byte;
		end
		if (head.in_stamp) begin
			stamp_nx[{head.idx[1:0], 3'b000} +: 8] = head.frame_byte;
		end
		crc_nx  = (fill_q >= 3'(TAIL_BYTES)) ? crc32_byte(crc_q, tail_q[31:24]) : crc_q;
		tail_nx = {tail_q[23:0], head.frame_byte};
		fill_nx = (fill_q < 3'(TAIL_BYTES)) ? fill_q + 1'b1 : fill_q;
	end

	// Classify payload and check the frame on its last word
	always_comb begin
		len      = header_nx[15:0];
		ptype    = header_nx[31:29];
		win      = header_nx[28:24];
		n        = {1'b0, head.idx} + 11'd1;
		body_end = 17'(PRE_BYTES) + {1'b0, len};
		emit_pay = head.in_body && ({7'b0, head.idx} < body_end);

		priority if (n < 11'(HDR_BYTES)) begin
			status = ST_INCONS;
		end else if (ptype != cfg.data_type_code && ptype != cfg.ack_type_code) begin
			status = ST_TYPE;
		end else if (win > cfg.max_window) begin
			status = ST_WINDOW;
		end else if (len > {6'b0, cfg.max_payload} || n > 11'(FRAME_LIMIT)) begin
			status = ST_LENGTH;
		end else if (17'(OVERHEAD) + {1'b0, len} != {6'b0, n}) begin
			status = ST_INCONS;
		end else if (~crc_nx != tail_nx) begin
			status = ST_CRC;
		end else begin
			status = ST_OK;
		end

		res.result_kind     = head.last ? KIND_STATUS : KIND_PAYLOAD;
		res.payload_byte    = head.last ? 8'h00 : head.frame_byte;
		res.packet_type     = ptype;
		res.window_size     = win;
		res.sequence_number = header_nx[23:16];
		res.payload_length  = len;
		res.time_stamp      = stamp_nx;
		res.received_crc    = head.last ? tail_nx : 32'h0;
		res.status          = head.last ? status : ST_OK;
	end

	// Update frame state; clear it after the last word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			header_q <= '0;
			stamp_q  <= '0;
			crc_q    <= CRC_INIT;
			tail_q   <= '0;
			fill_q   <= '0;
		end else if (pop) begin
			if (head.last) begin
				header_q <= '0;
				stamp_q  <= '0;
				crc_q    <= CRC_INIT;
				tail_q   <= '0;
				fill_q   <= '0;
			end else begin
				header_q <= header_nx;
				stamp_q  <= stamp_nx;
				crc_q    <= crc_nx;
				tail_q   <= tail_nx;
				fill_q   <= fill_nx;
			end
		end
	end

	// Hold the result until taken, load the next one behind it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (pop) begin
			out_valid_q <= head.last || emit_pay;
		end else if (result_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop && (head.last || emit_pay)) begin
			out_q <= res;
		end
	end

	a_clear_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && head.last) |=> (fill_q == '0 && crc_q == CRC_INIT && header_q == '0))
		else $error("frame state not cleared after last word");

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= 3'(TAIL_BYTES))
		else $error("tail fill count out of range");

	a_status_range: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_q.result_kind == KIND_STATUS) |-> out_q.status <= ST_CRC)
		else $error("status code out of range");

	a_no_pop_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !result_ready) |-> !pop)
		else $error("queue popped while result stalled");

endmodule

`default_nettype wire
